### rtl/sha1mh_pkg.sv
// Shared types and constants for the SHA-1 message hasher.
// Depends on nothing; imported by sha1_message_hasher_top and sha1_message_hasher_checker.
`default_nettype none

package sha1mh_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned BLOCK_W   = 512;
    localparam int unsigned ROUNDS    = 80;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [6:0] LAST_RND = 7'(ROUNDS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_ADD,
        S_PAD,
        S_LEN,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

### rtl/sha1_message_hasher_top.sv
// Streaming SHA-1 hasher: byte packing, padding sequencer and one shared round unit.
// Depends on sha1mh_pkg.
//
//  channel   dir  payload                                   when taken
//  s_axis    in   tdata=data_byte, tuser=has_byte, tlast=eom  tvalid & tready
//  m_axis    out  tdata=digest_word0..4 (160 bits)           tvalid & tready
//
// A byte is taken while s_axis_tready is high; the 64th byte of a block starts the
// rounds and then the chaining add in the single round unit, taking no bytes meanwhile.
// End of message writes one pad or length byte a cycle, pausing at the length position
// before the length bytes, compressing each filled block, then holds the digest until taken.
// s_axis_tready is low throughout. Reset (synchronous, active low) restores the
// initial constants and clears counts.
`default_nettype none

module sha1_message_hasher_top
    import sha1mh_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire logic [0:0]   s_axis_tuser,   // [0] has_byte
    input  wire logic         s_axis_tlast,   // end_of_message
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [159:0]      m_axis_tdata    // [31:0] word0 .. [159:128] word4
);

    t_state r_state, n_state;

    logic [5:0]          r_cnt;
    logic [63:0]         r_bitcnt;
    logic [6:0]          r_round;
    logic                r_fin, r_pad_done, r_last;
    logic [BLOCK_W-1:0]  r_sched;
    logic [WORD_W-1:0]   r_h [5];
    logic [WORD_W-1:0]   r_v [5];

    logic        in_acc;
    logic        shift_byte;
    logic [7:0]  shift_val;

    logic [WORD_W-1:0] w_cur, w_new, f_val, k_val, t_val;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser[0] && (r_cnt == LAST_POS)) begin
                        n_state = S_ROUND;
                    end else if (s_axis_tlast) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_ROUND: begin
                if (r_round == LAST_RND) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (r_last) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_PAD: begin
                if (r_pad_done && (r_cnt == LEN_POS)) begin
                    n_state = S_LEN;
                end else if (r_cnt == LAST_POS) begin
                    n_state = S_ROUND;
                end
            end
            S_LEN: begin
                if (r_cnt == LAST_POS) begin
                    n_state = S_ROUND;
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and byte-insert control
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        shift_byte    = 1'b0;
        shift_val     = s_axis_tdata;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                shift_byte    = s_axis_tvalid && s_axis_tuser[0];
            end
            S_PAD: begin
                shift_byte = !(r_pad_done && (r_cnt == LEN_POS));
                shift_val  = r_pad_done ? 8'h00 : PAD_BYTE;
            end
            S_LEN: begin
                shift_byte = 1'b1;
                shift_val  = r_bitcnt[63:56];
            end
            S_OUT: begin
                m_axis_tvalid = 1'b1;
            end
            S_ROUND, S_ADD: begin
                shift_byte = 1'b0;
            end
            default: begin
                shift_byte = 1'b0;
            end
        endcase
    end

    assign m_axis_tdata = {r_h[4], r_h[3], r_h[2], r_h[1], r_h[0]};

    // Round unit: window holds W[t..t+15], word 0 in the top bits
    assign w_cur = r_sched[511:480];
    always_comb begin
        logic [WORD_W-1:0] x;
        x     = r_sched[95:64] ^ r_sched[255:224] ^ r_sched[447:416] ^ r_sched[511:480];
        w_new = {x[30:0], x[31]};
    end

    always_comb begin
        if (r_round < 7'd20) begin
            f_val = (r_v[1] & r_v[2]) | (~r_v[1] & r_v[3]);
            k_val = K_R0;
        end else if (r_round < 7'd40) begin
            f_val = r_v[1] ^ r_v[2] ^ r_v[3];
            k_val = K_R1;
        end else if (r_round < 7'd60) begin
            f_val = (r_v[1] & r_v[2]) | (r_v[1] & r_v[3]) | (r_v[2] & r_v[3]);
            k_val = K_R2;
        end else begin
            f_val = r_v[1] ^ r_v[2] ^ r_v[3];
            k_val = K_R3;
        end
    end

    assign t_val = {r_v[0][26:0], r_v[0][31:27]} + f_val + r_v[4] + k_val + w_cur;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_bitcnt   <= '0;
            r_round    <= '0;
            r_fin      <= 1'b0;
            r_pad_done <= 1'b0;
            r_last     <= 1'b0;
            r_h[0]     <= H0_INIT;
            r_h[1]     <= H1_INIT;
            r_h[2]     <= H2_INIT;
            r_h[3]     <= H3_INIT;
            r_h[4]     <= H4_INIT;
            for (int i = 0; i < 5; i++) begin
                r_v[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (shift_byte) begin
                r_cnt <= r_cnt + 6'd1;
            end
            if (r_state == S_IDLE && shift_byte) begin
                r_bitcnt <= r_bitcnt + 64'd8;
            end else if (r_state == S_LEN) begin
                // consume the length MSB first
                r_bitcnt <= {r_bitcnt[55:0], 8'h00};
            end
            if (in_acc && s_axis_tlast) begin
                r_fin <= 1'b1;
            end
            if (r_state == S_PAD && shift_byte) begin
                r_pad_done <= 1'b1;
            end
            if (r_state == S_LEN && n_state == S_ROUND) begin
                r_last <= 1'b1;
            end
            if (n_state == S_ROUND && r_state != S_ROUND) begin
                r_round <= '0;
                for (int i = 0; i < 5; i++) begin
                    r_v[i] <= r_h[i];
                end
            end else if (r_state == S_ROUND) begin
                r_round <= (r_round == LAST_RND) ? 7'd0 : r_round + 7'd1;
                r_v[0]  <= t_val;
                r_v[1]  <= r_v[0];
                r_v[2]  <= {r_v[1][1:0], r_v[1][31:2]};
                r_v[3]  <= r_v[2];
                r_v[4]  <= r_v[3];
            end
            if (r_state == S_ADD) begin
                for (int i = 0; i < 5; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
            if (r_state == S_OUT && m_axis_tready) begin
                // restart for the next message
                r_cnt      <= '0;
                r_bitcnt   <= '0;
                r_fin      <= 1'b0;
                r_pad_done <= 1'b0;
                r_last     <= 1'b0;
                r_h[0]     <= H0_INIT;
                r_h[1]     <= H1_INIT;
                r_h[2]     <= H2_INIT;
                r_h[3]     <= H3_INIT;
                r_h[4]     <= H4_INIT;
            end
        end
    end

    // Message window: bytes shift in at the bottom, rounds shift by one word
    always_ff @(posedge i_clk) begin
        if (shift_byte) begin
            r_sched <= {r_sched[BLOCK_W-9:0], shift_val};
        end else if (r_state == S_ROUND) begin
            r_sched <= {r_sched[BLOCK_W-WORD_W-1:0], w_new};
        end
    end

    a_round_to_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_round == LAST_RND) |=> (r_state == S_ADD))
        else $error("last round did not lead to chaining add");

    a_round_block_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_cnt == 6'd0))
        else $error("compression started on a partial block");

    a_len_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEN && $past(r_state) == S_PAD) |-> (r_cnt == LEN_POS && r_pad_done))
        else $error("length field entered at wrong position");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=>
            (r_h[0] == H0_INIT && r_bitcnt == 64'd0 && !r_fin && r_state == S_IDLE))
        else $error("hasher did not restart after digest");

    a_out_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_fin && r_last && r_pad_done))
        else $error("digest presented before padding finished");

endmodule

`default_nettype wire

### tb/sha1_message_hasher_checker.sv
// Scoreboard for the SHA-1 message hasher: watches both stream channels,
// predicts each digest from the accepted bytes and compares field by field.
// Depends on sha1mh_pkg for the hash constants.
`timescale 1ns / 100ps

module sha1_message_hasher_checker
    import sha1mh_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    input  wire logic         i_in_ready,
    input  wire logic [7:0]   i_in_byte,
    input  wire logic         i_in_has_byte,
    input  wire logic         i_in_eom,
    input  wire logic         i_out_valid,
    input  wire logic         i_out_ready,
    input  wire logic [159:0] i_out_digest,
    output int                o_fail_count,
    output int                o_digests_owed
);

    typedef logic [4:0][31:0] t_digest;   // [0] is H0, the first printed word

    logic [31:0] chain [5];
    logic [7:0]  blk [64];
    int          fill;
    logic [63:0] bit_total;
    t_digest     pending_digests [$];

    initial begin
        o_fail_count   = 0;
        o_digests_owed = 0;
    end

    task automatic report_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    function automatic void restart_hash();
        chain[0]  = H0_INIT;
        chain[1]  = H1_INIT;
        chain[2]  = H2_INIT;
        chain[3]  = H3_INIT;
        chain[4]  = H4_INIT;
        fill      = 0;
        bit_total = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t, wt;
        int r;
        for (r = 0; r < 16; r++)
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (r = 0; r < 80; r++) begin
            if (r < 16) begin
                wt = w[r];
            end else begin
                wt = w[(r+13) & 15] ^ w[(r+8) & 15] ^ w[(r+2) & 15] ^ w[r & 15];
                wt = {wt[30:0], wt[31]};
                w[r & 15] = wt;
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_R0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_R1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_R2;
            end else begin
                f = b ^ c ^ d;
                k = K_R3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + wt;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    function automatic void take_byte(input logic [7:0] v);
        blk[fill] = v;
        fill++;
        bit_total += 64'd8;
        if (fill == 64) begin
            compress_block();
            fill = 0;
        end
    endfunction

    // Pad, append the big-endian bit length and hand back the digest.
    function automatic t_digest finish_message();
        logic [63:0] len_bits;
        t_digest dg;
        int i;
        len_bits  = bit_total;
        blk[fill] = PAD_BYTE;
        fill++;
        if (fill > LEN_POS) begin
            // pad landed in the length field: spill into a second block
            while (fill < 64) begin
                blk[fill] = 8'h00;
                fill++;
            end
            compress_block();
            fill = 0;
        end
        while (fill < LEN_POS) begin
            blk[fill] = 8'h00;
            fill++;
        end
        for (i = 0; i < 8; i++)
            blk[LEN_POS + i] = len_bits[63 - 8*i -: 8];
        compress_block();
        for (i = 0; i < 5; i++)
            dg[i] = chain[i];
        restart_hash();
        return dg;
    endfunction

    always @(posedge i_clk) begin
        t_digest got, want;
        int i;
        if (!i_rst_n) begin
            restart_hash();
            pending_digests.delete();
        end else begin
            // check the result side first so a same-edge digest cannot match itself
            if (i_out_valid && i_out_ready) begin
                got = i_out_digest;
                if (pending_digests.size() == 0) begin
                    report_error($sformatf("digest %h with none expected", got));
                end else begin
                    want = pending_digests.pop_front();
                    for (i = 0; i < 5; i++)
                        if (got[i] !== want[i])
                            report_error($sformatf("digest_word%0d got %h want %h",
                                                   i, got[i], want[i]));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_has_byte)
                    take_byte(i_in_byte);
                if (i_in_eom)
                    pending_digests.push_back(finish_message());
            end
        end
        o_digests_owed <= pending_digests.size();
    end

endmodule

### tb/sha1_message_hasher_top_tb.sv
// Stimulus and verdict for sha1_message_hasher_top: directed and random messages
// under several idle/stall mixes; checking lives in sha1_message_hasher_checker.
// Depends on sha1mh_pkg, sha1_message_hasher_top and sha1_message_hasher_checker.
`timescale 1ns / 100ps

module sha1_message_hasher_top_tb;

    localparam int IDLE_LIMIT   = 5000;   // cycles with no request moving on either side
    localparam int HOLD_CYCLES  = 600;
    localparam int BYTE_TARGET  = 1630;
    localparam int MSG_TARGET   = 20;
    localparam int PHASE_BYTES  = 350;
    localparam int DRAIN_CYCLES = 300;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;   // [7:0] data_byte
    logic [0:0]   s_axis_tuser;   // [0] has_byte
    logic         s_axis_tlast;   // end_of_message
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;   // [31:0] word0 .. [159:128] word4

    int fail_count;
    int digests_owed;
    int src_idle_pct;
    int snk_stall_pct;
    bit hold_start;
    bit hold_done;
    int hold_left;
    int bytes_sent;
    int msgs_sent;
    int quiet_cycles;

    sha1_message_hasher_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sha1_message_hasher_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .i_in_ready     (s_axis_tready),
        .i_in_byte      (s_axis_tdata),
        .i_in_has_byte  (s_axis_tuser[0]),
        .i_in_eom       (s_axis_tlast),
        .i_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .i_out_digest   (m_axis_tdata),
        .o_fail_count   (fail_count),
        .o_digests_owed (digests_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        hold_left     = 0;
        forever begin
            @(negedge i_clk);
            if (hold_start && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("sha1_message_hasher_top_tb: errors");
            $finish;
        end
    end

    // Offer one request and hold it until the hasher takes it.
    task automatic offer_request(input logic [7:0] b, input logic has, input logic eom);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= b;
        s_axis_tuser[0] <= has;
        s_axis_tlast    <= eom;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // Random bytes, rare empty items; the end rides on the last byte or follows on its own.
    task automatic send_message(input int len, input bit eom_on_byte);
        int i;
        bit last;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(99) < 5)
                offer_request(8'($urandom_range(255)), 1'b0, 1'b0);
            last = eom_on_byte && (i == len - 1);
            offer_request(8'($urandom_range(255)), 1'b1, last);
            bytes_sent++;
        end
        if (!(eom_on_byte && len > 0))
            offer_request(8'($urandom_range(255)), 1'b0, 1'b1);
        msgs_sent++;
    endtask

    function automatic int pick_length();
        case ($urandom_range(9))
            0:       return int'($urandom_range(3));
            1:       return int'($urandom_range(54, 57));
            2:       return int'($urandom_range(62, 65));
            3:       return int'($urandom_range(118, 121));
            4:       return int'($urandom_range(126, 130));
            default: return int'($urandom_range(1, 100));
        endcase
    endfunction

    // Walk through the idle mixes as the byte count grows.
    function automatic void set_phase();
        case ((bytes_sent / PHASE_BYTES) % 5)
            1:       begin src_idle_pct = 88; snk_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  snk_stall_pct = 88; end
            3:       begin src_idle_pct = 19; snk_stall_pct = 19; end
            default: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        endcase
    endfunction

    initial begin
        int len_list [6];
        int i;
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = '0;
        s_axis_tlast    = 1'b0;
        src_idle_pct    = 0;
        snk_stall_pct   = 0;
        hold_start      = 1'b0;
        bytes_sent      = 0;
        msgs_sent       = 0;
        quiet_cycles    = 0;
        len_list        = '{55, 56, 63, 64, 119, 120};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty message, then an item that carries nothing
        offer_request(8'h00, 1'b0, 1'b1);
        offer_request(8'hFF, 1'b0, 1'b0);
        // "abc" with the end on the last byte
        offer_request(8'h61, 1'b1, 1'b0);
        offer_request(8'h62, 1'b1, 1'b0);
        offer_request(8'h63, 1'b1, 1'b1);
        // one zero byte, an empty item, then a bare end
        offer_request(8'h00, 1'b1, 1'b0);
        offer_request(8'hA5, 1'b0, 1'b0);
        offer_request(8'h5A, 1'b0, 1'b1);
        // single all-ones byte carried on the end, then empty message again
        offer_request(8'hFF, 1'b1, 1'b1);
        offer_request(8'hFF, 1'b0, 1'b1);

        // stall the result side long enough for the input to back up
        hold_start = 1'b1;
        for (i = 0; i < 6; i++)
            send_message(len_list[i], i[0]);

        while (bytes_sent < BYTE_TARGET || msgs_sent < MSG_TARGET) begin
            set_phase();
            send_message(pick_length(), 1'($urandom_range(1)));
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (digests_owed != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && digests_owed == 0)
            $display("sha1_message_hasher_top_tb: clean");
        else
            $display("sha1_message_hasher_top_tb: errors");
        $finish;
    end

endmodule
